// ----- design/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Payload types, constants and the sector lookup for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // One input pixel
    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_pixel_t;

    // One output pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // Role a channel takes within a hue sector
    typedef enum logic [1:0] {
        ROLE_CHROMA,
        ROLE_X,
        ROLE_ZERO
    } chan_role_t;

    // Roles of red, green and blue, in that order
    typedef struct packed {
        chan_role_t red;
        chan_role_t green;
        chan_role_t blue;
    } sector_roles_t;

    localparam int HUE_SECTOR_DEG = 60;     // degrees per sector
    localparam int HUE_SECTORS    = 6;
    localparam int HUE_PERIOD_X   = 120;    // slope term repeats every two sectors
    localparam int X_DENOM        = 15300;  // 60 * 255
    // ceil(2^36 / 15300): exact floor quotient for all dividends below 2^22
    localparam int X_RECIP_SHIFT  = 36;
    localparam int X_RECIP        = 4491470;

    function automatic sector_roles_t sector_roles(input logic [2:0] sector);
        sector_roles_t r;
        case (sector)
            3'd0: r = '{ROLE_CHROMA, ROLE_X,      ROLE_ZERO};
            3'd1: r = '{ROLE_X,      ROLE_CHROMA, ROLE_ZERO};
            3'd2: r = '{ROLE_ZERO,   ROLE_CHROMA, ROLE_X};
            3'd3: r = '{ROLE_ZERO,   ROLE_X,      ROLE_CHROMA};
            3'd4: r = '{ROLE_X,      ROLE_ZERO,   ROLE_CHROMA};
            3'd5: r = '{ROLE_CHROMA, ROLE_ZERO,   ROLE_X};
            default: r = '{ROLE_ZERO, ROLE_ZERO,  ROLE_ZERO};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/hsv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Pipelined conversion of one HSV pixel to 8-bit RGB per clock while m_ready allows.
// ----------------------------------------------------------------------------
// Usage: push pixels on s_* (hue in whole degrees, saturation and brightness
// as 8-bit fractions where 255 is 1.0) and collect RGB on m_*. The pipeline
// takes one transaction per clock while m_ready lets results drain, and
// returns results in order. The four register stages are: hue sector split,
// first products, second products with the divide-by-255, and the
// reciprocal multiply for the x channel feeding the output register. Hue
// values 360..511 wrap and give the result of hue-360. Stalls from m_ready
// propagate back stage by stage; empty stages are filled so bubbles
// collapse, and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  hsvrgb_pkg::hsv_pixel_t  s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output hsvrgb_pkg::rgb_pixel_t  m_data
);
    import hsvrgb_pkg::*;

    // ---------------- handshake chain ----------------
    logic st1_valid_reg, st1_valid_next;
    logic st2_valid_reg, st2_valid_next;
    logic st3_valid_reg, st3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic st1_ready, st2_ready, st3_ready, out_ready;

    // A stage may load when it is empty or its contents move on
    assign out_ready = !out_valid_reg || m_ready;
    assign st3_ready = !st3_valid_reg || out_ready;
    assign st2_ready = !st2_valid_reg || st3_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st1_ready;

    assign st1_valid_next = st1_ready ? s_valid       : st1_valid_reg;
    assign st2_valid_next = st2_ready ? st1_valid_reg : st2_valid_reg;
    assign st3_valid_next = st3_ready ? st2_valid_reg : st3_valid_reg;
    assign out_valid_next = out_ready ? st3_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            st3_valid_reg <= st3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- stage 1: sector and distance from sector center -------
    // q = hue / 60 by threshold count (hue < 512, so q <= 8)
    logic [3:0] hue_q;
    logic [8:0] hue_phase;      // hue mod 120
    logic [2:0] sector_next;
    logic [5:0] dist_next;      // |phase - 60|, 0..60

    always_comb begin
        hue_q = 4'd0;
        for (int i = 1; i <= 8; i++) begin
            if (s_data.hue_degrees >= 9'(HUE_SECTOR_DEG * i)) begin
                hue_q = hue_q + 4'd1;
            end
        end
        sector_next = (hue_q >= 4'(HUE_SECTORS)) ? 3'(hue_q - 4'(HUE_SECTORS))
                                                 : hue_q[2:0];
        hue_phase = s_data.hue_degrees - 9'(9'(hue_q[3:1]) * 9'(HUE_PERIOD_X));
        if (hue_phase >= 9'(HUE_SECTOR_DEG)) begin
            dist_next = 6'(hue_phase - 9'(HUE_SECTOR_DEG));
        end else begin
            dist_next = 6'(9'(HUE_SECTOR_DEG) - hue_phase);
        end
    end

    logic [2:0] st1_sector_reg;
    logic [5:0] st1_dist_reg;
    logic [7:0] st1_sat_reg;
    logic [7:0] st1_bright_reg;

    always_ff @(posedge aclk) begin
        if (st1_ready && s_valid) begin
            st1_sector_reg <= sector_next;
            st1_dist_reg   <= dist_next;
            st1_sat_reg    <= s_data.saturation;
            st1_bright_reg <= s_data.brightness;
        end
    end

    // ---------------- stage 2: s*dist and v*(255-s) ----------------
    logic [13:0] sd_next;
    logic [15:0] zero_prod_next;

    assign sd_next        = 14'(st1_sat_reg) * 14'(st1_dist_reg);
    assign zero_prod_next = 16'(st1_bright_reg) * 16'(8'd255 - st1_sat_reg);

    logic [2:0]  st2_sector_reg;
    logic [13:0] st2_sd_reg;
    logic [15:0] st2_zero_prod_reg;
    logic [7:0]  st2_bright_reg;

    always_ff @(posedge aclk) begin
        if (st2_ready && st1_valid_reg) begin
            st2_sector_reg    <= st1_sector_reg;
            st2_sd_reg        <= sd_next;
            st2_zero_prod_reg <= zero_prod_next;
            st2_bright_reg    <= st1_bright_reg;
        end
    end

    // ---------------- stage 3: x numerator, zero channel /255 ---------------
    // x numerator = v * (15300 - s*dist), at most 255*15300 < 2^22
    logic [13:0] x_coef;
    logic [21:0] x_num_next;
    logic [15:0] zero_sum;
    logic [7:0]  zero_chan_next;

    assign x_coef     = 14'(X_DENOM) - st2_sd_reg;
    assign x_num_next = 22'(st2_bright_reg) * 22'(x_coef);
    // floor(p/255) = (p + (p>>8) + 1) >> 8 for p up to 255*255
    assign zero_sum       = st2_zero_prod_reg + {8'd0, st2_zero_prod_reg[15:8]} + 16'd1;
    assign zero_chan_next = zero_sum[15:8];

    logic [2:0]  st3_sector_reg;
    logic [21:0] st3_x_num_reg;
    logic [7:0]  st3_zero_reg;
    logic [7:0]  st3_bright_reg;

    always_ff @(posedge aclk) begin
        if (st3_ready && st2_valid_reg) begin
            st3_sector_reg <= st2_sector_reg;
            st3_x_num_reg  <= x_num_next;
            st3_zero_reg   <= zero_chan_next;
            st3_bright_reg <= st2_bright_reg;
        end
    end

    // ---------------- stage 4: x / 15300 by reciprocal, channel select -------
    logic [44:0]   x_prod;
    logic [7:0]    x_chan;
    sector_roles_t roles;
    rgb_pixel_t    out_data_next;
    rgb_pixel_t    out_data_reg;

    assign x_prod = 45'(st3_x_num_reg) * 45'(X_RECIP);
    assign x_chan = x_prod[X_RECIP_SHIFT +: 8];
    assign roles  = sector_roles(st3_sector_reg);

    function automatic logic [7:0] pick(input chan_role_t role, input logic [7:0] c,
                                        input logic [7:0] x, input logic [7:0] z);
        logic [7:0] r;
        case (role)
            ROLE_CHROMA: r = c;
            ROLE_X:      r = x;
            ROLE_ZERO:   r = z;
            default:     r = z;
        endcase
        return r;
    endfunction

    always_comb begin
        out_data_next.red   = pick(roles.red,   st3_bright_reg, x_chan, st3_zero_reg);
        out_data_next.green = pick(roles.green, st3_bright_reg, x_chan, st3_zero_reg);
        out_data_next.blue  = pick(roles.blue,  st3_bright_reg, x_chan, st3_zero_reg);
    end

    always_ff @(posedge aclk) begin
        if (out_ready && st3_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sim/hsv_to_rgb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both channels of the converter, computes the RGB pixel each
// accepted HSV transaction must produce, and compares results in order.
// ----------------------------------------------------------------------------

module hsv_to_rgb_checker (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    input  wire                     s_ready,
    input  hsvrgb_pkg::hsv_pixel_t  s_data,
    input  wire                     m_valid,
    input  wire                     m_ready,
    input  hsvrgb_pkg::rgb_pixel_t  m_data,
    output int                      fail_count,
    output int                      pending_count
);

    import hsvrgb_pkg::*;

    rgb_pixel_t rgb_pending_q[$];

    function automatic logic [7:0] level_for(input chan_role_t role, input logic [7:0] chroma,
                                             input logic [7:0] ramp, input logic [7:0] floor_lvl);
        case (role)
            ROLE_CHROMA: return chroma;
            ROLE_X:      return ramp;
            default:     return floor_lvl;
        endcase
    endfunction

    // v*(1-s) offset plus chroma / ramp / nothing, scaled to 255, truncated
    function automatic rgb_pixel_t convert_hsv(input hsv_pixel_t px);
        int unsigned   hue, sat, val, sector, phase, center_gap, slope, x_sum;
        logic [7:0]    lvl_chroma, lvl_x, lvl_zero;
        sector_roles_t roles;
        rgb_pixel_t    rgb;
        hue    = 32'(px.hue_degrees);
        sat    = 32'(px.saturation);
        val    = 32'(px.brightness);
        sector = (hue / HUE_SECTOR_DEG) % HUE_SECTORS;
        phase  = hue % HUE_PERIOD_X;
        center_gap = (phase >= HUE_SECTOR_DEG) ? phase - HUE_SECTOR_DEG
                                               : HUE_SECTOR_DEG - phase;
        slope  = HUE_SECTOR_DEG - center_gap;
        x_sum  = (X_DENOM * val - HUE_SECTOR_DEG * sat * val + sat * val * slope) / X_DENOM;
        lvl_chroma = val[7:0];
        lvl_x      = x_sum[7:0];
        x_sum      = (val * (255 - sat)) / 255;
        lvl_zero   = x_sum[7:0];
        case (sector)
            0:       roles = '{ROLE_CHROMA, ROLE_X,      ROLE_ZERO};
            1:       roles = '{ROLE_X,      ROLE_CHROMA, ROLE_ZERO};
            2:       roles = '{ROLE_ZERO,   ROLE_CHROMA, ROLE_X};
            3:       roles = '{ROLE_ZERO,   ROLE_X,      ROLE_CHROMA};
            4:       roles = '{ROLE_X,      ROLE_ZERO,   ROLE_CHROMA};
            default: roles = '{ROLE_CHROMA, ROLE_ZERO,   ROLE_X};
        endcase
        rgb.red   = level_for(roles.red,   lvl_chroma, lvl_x, lvl_zero);
        rgb.green = level_for(roles.green, lvl_chroma, lvl_x, lvl_zero);
        rgb.blue  = level_for(roles.blue,  lvl_chroma, lvl_x, lvl_zero);
        return rgb;
    endfunction

    always @(posedge aclk) begin
        rgb_pixel_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                rgb_pending_q.push_back(convert_hsv(s_data));
            if (m_valid && m_ready) begin
                if (rgb_pending_q.size() == 0) begin
                    $error("unexpected result transaction: %0d %0d %0d",
                           m_data.red, m_data.green, m_data.blue);
                    fail_count = fail_count + 1;
                end else begin
                    want = rgb_pending_q.pop_front();
                    if (m_data.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, m_data.red);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, m_data.green);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, m_data.blue);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_count = rgb_pending_q.size();
        end
    end

endmodule

// ----- sim/tb_hsv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_core
// Drives HSV pixels into the converter under changing backpressure and lets
// the checker compare every RGB result; prints the verdict at the end.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_core;

    import hsvrgb_pkg::*;

    localparam int    CLK_HALF        = 5;
    localparam int    RESET_CYCLES    = 8;
    localparam int    ITEMS_PER_PHASE = 270;
    localparam int    BURST_ITEMS     = 40;     // offered while the receiver holds off
    localparam int    HOLD_OFF_CYCLES = 200;
    localparam int    DRAIN_CYCLES    = 20;     // four pipe stages, plus margin
    localparam longint RUN_LIMIT_NS   = 2_000_000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    hsv_pixel_t s_data;
    logic       m_valid;
    logic       m_ready;
    rgb_pixel_t m_data;

    int fail_count;
    int pending_count;

    // idle odds in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_reqs;      // bumped once per requested hold-off

    hsv_to_rgb_converter_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hsv_to_rgb_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random ready at each falling edge. A hold-off request drops
    // ready for a long stretch so the pipe fills and s_ready goes low.
    initial begin : receiver
        int hold_off_seen;
        hold_off_seen = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_reqs != hold_off_seen) begin
                m_ready <= 1'b0;
                hold_off_seen = hold_off_reqs;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one pixel, with a random geometric gap ahead of it, and hold it
    // until the transaction is taken. Valid only drops during a gap.
    task automatic send_pixel(input hsv_pixel_t px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic send_hsv(input int hue, input int sat, input int val);
        hsv_pixel_t px;
        px.hue_degrees = hue[8:0];
        px.saturation  = sat[7:0];
        px.brightness  = val[7:0];
        send_pixel(px);
    endtask

    // Stop offering and wait until every predicted pixel has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // Mostly legal hues with random content; some wrapped hues (360..511)
    // and the full 9-bit range so every input bit toggles. Saturation and
    // value lean on the 0 and 255 ends now and then.
    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 75)
            px.hue_degrees = 9'($urandom_range(359));
        else if (pick < 90)
            px.hue_degrees = 9'($urandom_range(511, 360));
        else
            px.hue_degrees = 9'($urandom_range(511));
        pick = $urandom_range(99);
        px.saturation = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom_range(255));
        pick = $urandom_range(99);
        px.brightness = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom_range(255));
        return px;
    endfunction

    task automatic random_phase(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pixel(random_pixel());
        drain_results();
    endtask

    initial begin
        // every input known from time zero; reset is synchronous
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 29;
        recv_idle_pct = 72;
        hold_off_reqs = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: sector edges on both sides of every 60 degree boundary
        send_hsv(0,   255, 255);
        send_hsv(59,  255, 255);
        send_hsv(60,  255, 255);
        send_hsv(119, 200, 180);
        send_hsv(120, 255, 255);
        send_hsv(179, 128, 255);
        send_hsv(180, 255, 255);
        send_hsv(239, 77,  201);
        send_hsv(240, 255, 255);
        send_hsv(299, 255, 128);
        send_hsv(300, 255, 255);
        send_hsv(359, 255, 255);
        // zero saturation gives grey, zero value gives black
        send_hsv(30,  0,   255);
        send_hsv(210, 0,   97);
        send_hsv(90,  255, 0);
        send_hsv(330, 0,   0);
        // wrapped hues must match hue minus 360
        send_hsv(360, 255, 255);
        send_hsv(419, 180, 220);
        send_hsv(420, 255, 255);
        send_hsv(479, 99,  240);
        send_hsv(480, 255, 255);
        send_hsv(511, 255, 255);
        // mid ramp and small values
        send_hsv(45,  1,   1);
        send_hsv(150, 254, 254);
        // sender pause: nothing new until every result is back
        drain_results();

        // slow sink, then slow source
        random_phase(ITEMS_PER_PHASE, 29, 72);
        random_phase(ITEMS_PER_PHASE, 72, 29);

        // Back-to-back burst against a long hold-off on the result side,
        // so the pipe fills and the input stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_reqs = hold_off_reqs + 1;
        repeat (BURST_ITEMS) send_pixel(random_pixel());

        // no idling on either side
        random_phase(ITEMS_PER_PHASE, 0, 0);

        // let any straggler show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/hsvrgb_pkg.sv
design/hsv_to_rgb_converter_core.sv
sim/hsv_to_rgb_checker.sv
sim/tb_hsv_to_rgb_converter_core.sv
